// ----- rtl/ddp_seg_pkg.sv -----
package ddp_seg_pkg;

  localparam logic [7:0]  CtrlTagged     = 8'h81;
  localparam logic [7:0]  CtrlUntagged   = 8'h01;
  localparam logic [7:0]  CtrlLast       = 8'h40;
  localparam logic [4:0]  TaggedHdrLen   = 5'd14;
  localparam logic [4:0]  UntaggedHdrLen = 5'd18;
  localparam int unsigned HdrMaxBytes    = 18;
  localparam logic [15:0] MaxUlpduReset  = 16'd1024;

  // One framed item: optional header, then the payload byte.
  typedef struct packed {
    logic                             emits;
    logic [4:0]                       hdr_len;  // 0 when no header goes out
    logic [HdrMaxBytes-1:0][7:0]      hdr;      // element 0 goes out first
    logic [7:0]                       data;
    logic                             seg_end;
  } job_t;

endpackage

// ----- rtl/ddp_seg_ctrl.sv -----
module ddp_seg_ctrl
  import ddp_seg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_max_ulpdu_bytes_i,
  input  logic        accept_i,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic        message_start_i,
  input  logic [31:0] message_length_i,
  input  logic [31:0] steering_tag_i,
  input  logic [63:0] start_offset_i,
  input  logic [39:0] reserved_ulp_i,
  input  logic [31:0] queue_number_i,
  input  logic [31:0] message_seq_i,
  output job_t        job_o
);

  logic [15:0] max_ulpdu_q;
  logic        mode_tagged_q;
  logic [31:0] bytes_remaining_q;
  logic [15:0] segment_bytes_left_q;
  logic [63:0] running_offset_q;
  logic [31:0] latched_stag_q;
  logic [39:0] latched_reserved_q;
  logic [31:0] latched_queue_q;
  logic [31:0] latched_seq_q;

  logic        eff_tagged;
  logic [31:0] eff_rem;
  logic [15:0] eff_seg;
  logic [63:0] eff_off;
  logic [31:0] eff_stag;
  logic [39:0] eff_res;
  logic [31:0] eff_queue;
  logic [31:0] eff_seq;
  logic [4:0]  hdr_len;
  logic [15:0] hdr_len_w;
  logic [15:0] cap;
  logic        last;
  logic        need_hdr;
  logic        have;
  logic [15:0] seg_new;
  logic [7:0]  ctrl_byte;

  // Merge the start fields over the held message context.
  always_comb begin
    if (message_start_i) begin
      eff_tagged = cmd_i;
      eff_rem    = message_length_i;
      eff_seg    = '0;
      eff_off    = cmd_i ? start_offset_i : '0;
      eff_stag   = steering_tag_i;
      eff_res    = reserved_ulp_i;
      eff_queue  = queue_number_i;
      eff_seq    = message_seq_i;
    end else begin
      eff_tagged = mode_tagged_q;
      eff_rem    = bytes_remaining_q;
      eff_seg    = segment_bytes_left_q;
      eff_off    = running_offset_q;
      eff_stag   = latched_stag_q;
      eff_res    = latched_reserved_q;
      eff_queue  = latched_queue_q;
      eff_seq    = latched_seq_q;
    end
  end

  assign hdr_len   = eff_tagged ? TaggedHdrLen : UntaggedHdrLen;
  assign hdr_len_w = {11'b0, hdr_len};
  assign cap       = (max_ulpdu_q > hdr_len_w) ? (max_ulpdu_q - hdr_len_w) : 16'd1;
  assign last      = eff_rem <= {16'b0, cap};
  assign need_hdr  = eff_seg == '0;
  assign have      = eff_rem != '0;
  assign seg_new   = need_hdr ? (last ? eff_rem[15:0] : cap) : eff_seg;
  assign ctrl_byte = (eff_tagged ? CtrlTagged : CtrlUntagged) | (last ? CtrlLast : 8'h00);

  always_comb begin
    job_o         = '0;
    job_o.emits   = have;
    job_o.hdr_len = need_hdr ? hdr_len : 5'd0;
    job_o.data    = data_byte_i;
    job_o.seg_end = seg_new == 16'd1;
    job_o.hdr[0]  = ctrl_byte;
    if (eff_tagged) begin
      job_o.hdr[1] = eff_res[7:0];
      for (int i = 0; i < 4; i++) begin
        job_o.hdr[2+i] = eff_stag[8*(3-i) +: 8];
      end
      for (int i = 0; i < 8; i++) begin
        job_o.hdr[6+i] = eff_off[8*(7-i) +: 8];
      end
    end else begin
      for (int i = 0; i < 5; i++) begin
        job_o.hdr[1+i] = eff_res[8*(4-i) +: 8];
      end
      for (int i = 0; i < 4; i++) begin
        job_o.hdr[6+i]  = eff_queue[8*(3-i) +: 8];
        job_o.hdr[10+i] = eff_seq[8*(3-i) +: 8];
        job_o.hdr[14+i] = eff_off[8*(3-i) +: 8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ulpdu_q <= MaxUlpduReset;
    end else if (cfg_we_i) begin
      max_ulpdu_q <= cfg_max_ulpdu_bytes_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_tagged_q        <= 1'b0;
      bytes_remaining_q    <= '0;
      segment_bytes_left_q <= '0;
      running_offset_q     <= '0;
      latched_stag_q       <= '0;
      latched_reserved_q   <= '0;
      latched_queue_q      <= '0;
      latched_seq_q        <= '0;
    end else if (accept_i) begin
      mode_tagged_q      <= eff_tagged;
      latched_stag_q     <= eff_stag;
      latched_reserved_q <= eff_res;
      latched_queue_q    <= eff_queue;
      latched_seq_q      <= eff_seq;
      if (have) begin
        bytes_remaining_q    <= eff_rem - 32'd1;
        segment_bytes_left_q <= seg_new - 16'd1;
        running_offset_q     <= eff_off + 64'd1;
      end else begin
        bytes_remaining_q    <= eff_rem;
        segment_bytes_left_q <= eff_seg;
        running_offset_q     <= eff_off;
      end
    end
  end

endmodule

// ----- rtl/ddp_seg_emit.sv -----
module ddp_seg_emit
  import ddp_seg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  job_t       job_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_header_o,
  output logic       segment_end_o,
  output logic       run_end_o
);

  logic       job_valid_q;
  job_t       job_q;
  logic [4:0] idx_q;
  logic       cur_hdr;
  logic       load;

  assign cur_hdr    = idx_q < job_q.hdr_len;
  assign in_ready_o = !job_valid_q || (out_ready_i && !cur_hdr);
  assign load       = in_valid_i && in_ready_o;

  assign out_valid_o   = job_valid_q;
  assign out_byte_o    = cur_hdr ? job_q.hdr[idx_q] : job_q.data;
  assign is_header_o   = cur_hdr;
  assign segment_end_o = !cur_hdr && job_q.seg_end;
  assign run_end_o     = !cur_hdr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      job_valid_q <= job_i.emits;
      idx_q       <= '0;
    end else if (job_valid_q && out_ready_i) begin
      // advance through the header; the payload byte retires the job
      if (cur_hdr) begin
        idx_q <= idx_q + 5'd1;
      end else begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
  end

endmodule

// ----- rtl/ddp_segment_framer.sv -----
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid/in_ready     | cmd, data_byte, message_start, message_length,
//         |           |                       | steering_tag, start_offset, reserved_ulp,
//         |           |                       | queue_number, message_seq
// out     | output    | out_valid/out_ready   | out_byte, is_header, segment_end, run_end
// cfg     | input     | cfg_valid/cfg_ready   | cfg_max_ulpdu_bytes (always ready)
//
// A payload byte inside a segment goes out alone; a byte that opens a segment follows
// 14 header bytes (tagged) or 18 header bytes (untagged), sent by the one-byte-per-cycle
// output serializer while out is not stalled. Transactions that produce nothing send no byte.
// A new transaction is taken in the same cycle the previous job's payload byte leaves.
// Reset returns the segment size register to 1024 and clears all message context.
// A stall on out holds the current byte and, once the job register is busy, stalls in.
module ddp_segment_framer
  import ddp_seg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_max_ulpdu_bytes_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic        message_start_i,
  input  logic [31:0] message_length_i,
  input  logic [31:0] steering_tag_i,
  input  logic [63:0] start_offset_i,
  input  logic [39:0] reserved_ulp_i,
  input  logic [31:0] queue_number_i,
  input  logic [31:0] message_seq_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_header_o,
  output logic        segment_end_o,
  output logic        run_end_o
);

  job_t job;
  logic in_accept;

  // Config writes land at once; software must write only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  // Segment state, header assembly and the next job, all from one input transaction.
  ddp_seg_ctrl u_ctrl (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_valid_i),
    .cfg_max_ulpdu_bytes_i (cfg_max_ulpdu_bytes_i),
    .accept_i              (in_accept),
    .cmd_i                 (cmd_i),
    .data_byte_i           (data_byte_i),
    .message_start_i       (message_start_i),
    .message_length_i      (message_length_i),
    .steering_tag_i        (steering_tag_i),
    .start_offset_i        (start_offset_i),
    .reserved_ulp_i        (reserved_ulp_i),
    .queue_number_i        (queue_number_i),
    .message_seq_i         (message_seq_i),
    .job_o                 (job)
  );

  // Job register and byte serializer: header bytes first, then the payload byte.
  ddp_seg_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .job_i         (job),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .is_header_o   (is_header_o),
    .segment_end_o (segment_end_o),
    .run_end_o     (run_end_o)
  );

endmodule

// ----- rtl/ddp_seg_chk.sv -----
module ddp_seg_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_header_o,
  input logic       segment_end_o,
  input logic       run_end_o
);

  // Hold a stalled output transaction.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("out transaction dropped or changed under stall");

  // Header bytes never close a segment or a run.
  a_hdr_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_header_o |-> !segment_end_o && !run_end_o)
    else $error("header byte flagged as segment or run end");

  // Each run ends on its payload byte.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_header_o |-> run_end_o)
    else $error("payload byte not flagged as run end");

  // Header bytes stream without gaps until the payload byte.
  a_hdr_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && is_header_o |=> out_valid_o)
    else $error("gap after header byte");

endmodule

bind ddp_segment_framer ddp_seg_chk u_ddp_seg_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .is_header_o   (is_header_o),
  .segment_end_o (segment_end_o),
  .run_end_o     (run_end_o)
);
